// ===== hw/rtl/tdma_slot_gate_timer_top_macros.svh =====
// Assertion macros shared by the TDMA slot gate timer RTL.
// Each macro expands to one labelled concurrent assertion clocked on aclk
// and switched off while aresetn is low.
`ifndef TDMA_SLOT_GATE_TIMER_TOP_MACROS_SVH
`define TDMA_SLOT_GATE_TIMER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDMA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TDMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tdma_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tdma_pkg;

    // Request kinds carried on the input channel.
    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_RESYNC = 2'd1,
        MODE_START  = 2'd2,
        MODE_STOP   = 2'd3
    } mode_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SLOT_TICKS        = 3'd0;
    localparam logic [2:0] CFG_SLOTS_PER_FRAME   = 3'd1;
    localparam logic [2:0] CFG_OWNED_MASK        = 3'd2;
    localparam logic [2:0] CFG_FRAME_LIMIT       = 3'd3;
    localparam logic [2:0] CFG_FIRST_FRAME_START = 3'd4;

    localparam logic [6:0] MAX_SLOTS = 7'd64;

    // One result request.
    typedef struct packed {
        logic       transmit_enable;
        logic [5:0] slot_number;
        logic       in_frame;
        logic       frame_end;
        logic       active;
    } result_t;

    // A slot length of zero behaves as one tick.
    function automatic logic [23:0] eff_ticks(input logic [23:0] ticks);
        eff_ticks = (ticks == 24'd0) ? 24'd1 : ticks;
    endfunction

    // Slot count is held between one and the maximum slot count.
    function automatic logic [6:0] eff_slots(input logic [6:0] slots);
        if (slots == 7'd0) begin
            eff_slots = 7'd1;
        end else if (slots > MAX_SLOTS) begin
            eff_slots = MAX_SLOTS;
        end else begin
            eff_slots = slots;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tdma_slot_gate_timer_top.sv =====
// Throughput: one request per clock cycle while s_ready is high; every request yields
// exactly one result. A two-entry output stage (output register plus skid register)
// registers each result at the edge that accepts its request and keeps s_ready high
// while a single result waits, so a stall on m_ready throttles the input only once the
// skid register fills. Reset (aresetn low, synchronous) restores the documented register
// values, stops the scheduler and empties the output stage; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

`include "tdma_slot_gate_timer_top_macros.svh"

module tdma_slot_gate_timer_top #(
    parameter int TIME_WIDTH = 48
) (
    input  wire         aclk,
    input  wire         aresetn,
    // Configuration write port
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_index,
    input  wire  [63:0] cfg_wdata,
    // Input request channel
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [1:0]  s_mode,
    input  wire  [47:0] s_beacon_time,
    // Result channel
    output logic        m_valid,
    input  wire         m_ready,
    output logic        m_transmit_enable,
    output logic [5:0]  m_slot_number,
    output logic        m_in_frame,
    output logic        m_frame_end,
    output logic        m_active
);
    import tdma_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. The frame length (ticks times slots) is kept
    // in a register of its own and refreshed when either factor is written,
    // so the multiplier sits on the configuration path and never on the
    // per-request path.
    // ------------------------------------------------------------------
    logic [23:0] slot_ticks_reg;
    logic [6:0]  slots_per_frame_reg;
    logic [63:0] owned_mask_reg;
    logic [31:0] frame_limit_reg;
    logic [30:0] frame_len_reg;

    logic [23:0] len_ticks;
    logic [6:0]  len_slots;
    logic [30:0] frame_len_next;

    always_comb begin
        len_ticks = eff_ticks(slot_ticks_reg);
        len_slots = eff_slots(slots_per_frame_reg);
        if (cfg_index == CFG_SLOT_TICKS) begin
            len_ticks = eff_ticks(cfg_wdata[23:0]);
        end
        if (cfg_index == CFG_SLOTS_PER_FRAME) begin
            len_slots = eff_slots(cfg_wdata[6:0]);
        end
        frame_len_next = {7'd0, len_ticks} * {24'd0, len_slots};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_ticks_reg      <= 24'd1000;
            slots_per_frame_reg <= 7'd10;
            owned_mask_reg      <= 64'd1;
            frame_limit_reg     <= 32'd0;
            frame_len_reg       <= 31'd10000;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SLOT_TICKS: begin
                    slot_ticks_reg <= cfg_wdata[23:0];
                    frame_len_reg  <= frame_len_next;
                end
                CFG_SLOTS_PER_FRAME: begin
                    slots_per_frame_reg <= cfg_wdata[6:0];
                    frame_len_reg       <= frame_len_next;
                end
                CFG_OWNED_MASK: begin
                    owned_mask_reg <= cfg_wdata;
                end
                CFG_FRAME_LIMIT: begin
                    frame_limit_reg <= cfg_wdata[31:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Widen the configured quantities to the local time width.
    logic [63:0]           frame_len_wide;
    logic [63:0]           first_start_wide;
    logic [63:0]           beacon_wide;
    logic [TIME_WIDTH-1:0] frame_len_t;
    logic [TIME_WIDTH-1:0] first_start_t;
    logic [TIME_WIDTH-1:0] beacon_t;

    assign frame_len_wide   = {33'd0, frame_len_reg};
    assign first_start_wide = {16'd0, cfg_wdata[47:0]};
    assign beacon_wide      = {16'd0, s_beacon_time};
    assign frame_len_t      = frame_len_wide[TIME_WIDTH-1:0];
    assign first_start_t    = first_start_wide[TIME_WIDTH-1:0];
    assign beacon_t         = beacon_wide[TIME_WIDTH-1:0];

    // ------------------------------------------------------------------
    // Scheduler state
    // ------------------------------------------------------------------
    logic [TIME_WIDTH-1:0] local_time_reg,      local_time_next;
    logic [TIME_WIDTH-1:0] next_frame_time_reg, next_frame_time_next;
    logic [TIME_WIDTH-1:0] resync_time_reg,     resync_time_next;
    logic                  resync_pending_reg,  resync_pending_next;
    logic                  running_reg,         running_next;
    logic                  frame_active_reg,    frame_active_next;
    logic [5:0]            slot_position_reg,   slot_position_next;
    logic [23:0]           tick_position_reg,   tick_position_next;
    logic [31:0]           frames_remaining_reg, frames_remaining_next;

    logic                  accept;
    mode_t                 mode;
    logic [TIME_WIDTH-1:0] local_time_inc;
    logic [TIME_WIDTH-1:0] time_late;
    logic                  start_due;
    logic                  limit_on;
    logic [23:0]           tick_inc;
    logic [6:0]            slot_inc;
    result_t               result;

    assign accept         = s_valid && s_ready;
    assign mode           = mode_t'(s_mode);
    assign local_time_inc = local_time_reg + {{(TIME_WIDTH-1){1'b0}}, 1'b1};
    // The frame start counts as reached while local time is late by less
    // than half the time range, so the comparison survives wrap-around.
    assign time_late      = local_time_reg - next_frame_time_reg;
    assign start_due      = !time_late[TIME_WIDTH-1];
    assign limit_on       = (frame_limit_reg != 32'd0);

    always_comb begin
        local_time_next       = local_time_reg;
        next_frame_time_next  = next_frame_time_reg;
        resync_time_next      = resync_time_reg;
        resync_pending_next   = resync_pending_reg;
        running_next          = running_reg;
        frame_active_next     = frame_active_reg;
        slot_position_next    = slot_position_reg;
        tick_position_next    = tick_position_reg;
        frames_remaining_next = frames_remaining_reg;
        tick_inc              = 24'd0;
        slot_inc              = 7'd0;
        result                = '0;

        if (accept) begin
            // A tick may open a frame before it is counted.
            if ((mode == MODE_TICK) && !frame_active_reg && running_reg && start_due) begin
                if (limit_on && (frames_remaining_reg == 32'd0)) begin
                    running_next = 1'b0;
                end else begin
                    if (limit_on) begin
                        frames_remaining_next = frames_remaining_reg - 32'd1;
                    end
                    frame_active_next  = 1'b1;
                    slot_position_next = 6'd0;
                    tick_position_next = 24'd0;
                end
            end

            // The result names the slot this request falls into.
            result.slot_number     = frame_active_next ? slot_position_next : 6'd0;
            result.transmit_enable = frame_active_next && owned_mask_reg[slot_position_next];

            case (mode)
                MODE_TICK: begin
                    if (frame_active_next) begin
                        tick_inc = tick_position_next + 24'd1;
                        if (tick_inc >= eff_ticks(slot_ticks_reg)) begin
                            tick_position_next = 24'd0;
                            slot_inc = {1'b0, slot_position_next} + 7'd1;
                            if (slot_inc >= eff_slots(slots_per_frame_reg)) begin
                                // Last tick of the last slot closes the frame.
                                slot_position_next = 6'd0;
                                frame_active_next  = 1'b0;
                                result.frame_end   = 1'b1;
                                if (resync_pending_reg) begin
                                    next_frame_time_next = resync_time_reg;
                                    resync_pending_next  = 1'b0;
                                end else begin
                                    next_frame_time_next = next_frame_time_reg + frame_len_t;
                                end
                                if (limit_on && (frames_remaining_next == 32'd0)) begin
                                    running_next = 1'b0;
                                end
                            end else begin
                                slot_position_next = slot_inc[5:0];
                            end
                        end else begin
                            tick_position_next = tick_inc;
                        end
                    end
                    local_time_next = local_time_inc;
                end
                MODE_RESYNC: begin
                    // A resync during a frame waits for the frame to end.
                    resync_time_next = beacon_t + frame_len_t;
                    if (frame_active_reg) begin
                        resync_pending_next = 1'b1;
                    end else begin
                        next_frame_time_next = beacon_t + frame_len_t;
                        resync_pending_next  = 1'b0;
                    end
                end
                MODE_START: begin
                    running_next          = 1'b1;
                    frames_remaining_next = frame_limit_reg;
                end
                MODE_STOP: begin
                    running_next = 1'b0;
                end
                default: begin
                end
            endcase

            result.in_frame = frame_active_next;
            result.active   = running_next || frame_active_next;
        end

        // Writing the first frame start also reloads the next frame time.
        if (cfg_we && (cfg_index == CFG_FIRST_FRAME_START)) begin
            next_frame_time_next = first_start_t;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_time_reg       <= '0;
            next_frame_time_reg  <= '0;
            resync_time_reg      <= '0;
            resync_pending_reg   <= 1'b0;
            running_reg          <= 1'b0;
            frame_active_reg     <= 1'b0;
            slot_position_reg    <= 6'd0;
            tick_position_reg    <= 24'd0;
            frames_remaining_reg <= 32'd0;
        end else begin
            local_time_reg       <= local_time_next;
            next_frame_time_reg  <= next_frame_time_next;
            resync_time_reg      <= resync_time_next;
            resync_pending_reg   <= resync_pending_next;
            running_reg          <= running_next;
            frame_active_reg     <= frame_active_next;
            slot_position_reg    <= slot_position_next;
            tick_position_reg    <= tick_position_next;
            frames_remaining_reg <= frames_remaining_next;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: an output register with a skid register behind it. A
    // new request is taken whenever the skid register is free, so a single
    // waiting result never blocks the input.
    // ------------------------------------------------------------------
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    pop;

    assign s_ready = !skid_valid_reg;
    assign pop     = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || pop) begin
            out_valid_reg <= accept;
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (!out_valid_reg || pop) begin
            out_reg <= result;
        end else if (accept) begin
            skid_reg <= result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_transmit_enable = out_reg.transmit_enable;
    assign m_slot_number     = out_reg.slot_number;
    assign m_in_frame        = out_reg.in_frame;
    assign m_frame_end       = out_reg.frame_end;
    assign m_active          = out_reg.active;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic gate_open;
    logic frame_shown;
    logic tick_accept;
    logic event_accept;

    assign gate_open    = m_valid && m_transmit_enable;
    assign frame_shown  = m_in_frame || m_frame_end;
    assign tick_accept  = accept && (mode == MODE_TICK);
    assign event_accept = accept && (mode != MODE_TICK);

    // The skid register is only ever filled behind an occupied output register.
    `TDMA_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid full, output empty")
    // The gate can only be open inside a frame, or on the tick that closes it.
    `TDMA_ASSERT_SAME(a_gate_in_frame, gate_open, frame_shown, "gate open outside a frame")
    // Every accepted tick advances local time by exactly one.
    `TDMA_ASSERT_NEXT(a_tick_advances, tick_accept, local_time_reg == $past(local_time_inc), "tick lost")
    // Resync, start and stop requests leave local time alone.
    `TDMA_ASSERT_NEXT(a_event_holds_time, event_accept, $stable(local_time_reg), "time moved")

endmodule

`default_nettype wire
